### src/cspe_pkg.sv
// Shared types and constants for the cardinal spline point evaluator.
// Used by every module of the block; depends on nothing else.

package cspe_pkg;

    // Register field widths and reset values.
    localparam int TENSION_W = 16;
    localparam int FPS_W     = 11;
    localparam int FRAME_W   = 10;
    localparam logic [TENSION_W-1:0] TENSION_RST = 16'd8192;
    localparam logic [FPS_W-1:0]     FPS_RST     = 11'd10;

    // Allowed range of the effective frames-per-segment value.
    localparam int MAX_SEG_FRAMES = 1024;
    localparam int FPS_MAX_CODE   = (1 << FPS_W) - 1;
    localparam logic [FPS_W-1:0] F_LO = FPS_W'(2);
    localparam logic [FPS_W-1:0] F_HI =
        FPS_W'((MAX_SEG_FRAMES > FPS_MAX_CODE) ? FPS_MAX_CODE : MAX_SEG_FRAMES);

    // Fixed-point formats.
    localparam int RECIP_W     = 32;   // floor(2^32 / F)
    localparam int Q_FRAC      = 16;   // Q16 basis arithmetic
    localparam int Q16_W       = 17;   // 0 .. 65536
    localparam int H_W         = 19;   // signed Hermite weights
    localparam int TENSION_FRAC = 14;

    // Pipeline depths.
    localparam int BASIS_LAT  = 7;
    localparam int DERIV_LAT  = 3;
    localparam int LANE_LAT   = BASIS_LAT + 3;
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Register map: index is the word address.
    typedef enum logic {
        REG_TENSION = 1'b0,
        REG_FPS     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic               busy;
        logic [RECIP_W-1:0] recip;
    } t_recip_stat;

    typedef struct packed {
        logic signed [H_W-1:0] h1;
        logic signed [H_W-1:0] h2;
        logic signed [H_W-1:0] h3;
        logic signed [H_W-1:0] h4;
    } t_basis;

endpackage

### src/cspe_recip.sv
// Bit-serial reciprocal unit: computes floor(2^32 / F) one quotient bit per cycle.
// Depends on cspe_pkg.

module cspe_recip (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cspe_pkg::FPS_W-1:0]  i_frames,
    output cspe_pkg::t_recip_stat       o_stat
);

    localparam int ITER_W = $clog2(cspe_pkg::RECIP_W);

    logic                            r_busy;
    logic [ITER_W-1:0]               r_cnt;
    logic [cspe_pkg::FPS_W-1:0]      r_rem;
    logic [cspe_pkg::RECIP_W-1:0]    r_quo;

    logic [cspe_pkg::FPS_W:0]        rem_sh;
    logic [cspe_pkg::FPS_W:0]        rem_sub;
    logic                            ge;
    logic [cspe_pkg::FPS_W-1:0]      n_rem;
    logic [cspe_pkg::RECIP_W-1:0]    n_quo;

    // The dividend is a one followed by 32 zeros; the leading one seeds the
    // remainder, and each step shifts in one zero.
    always_comb begin
        rem_sh  = {r_rem, 1'b0};
        ge      = (rem_sh >= {1'b0, i_frames});
        rem_sub = rem_sh - {1'b0, i_frames};
        n_rem   = ge ? rem_sub[cspe_pkg::FPS_W-1:0] : rem_sh[cspe_pkg::FPS_W-1:0];
        n_quo   = {r_quo[cspe_pkg::RECIP_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= cspe_pkg::FPS_W'(1);
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + ITER_W'(1);
            if (r_cnt == ITER_W'(cspe_pkg::RECIP_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.recip = r_quo;

endmodule

### src/cspe_basis.sv
// Hermite basis pipeline: s = t/F through the stored reciprocal, then s^2, s^3
// and the four weights. Shared by both coordinate lanes. Depends on cspe_pkg.

module cspe_basis (
    input  logic                          i_clk,
    input  logic [cspe_pkg::FRAME_W-1:0]  i_t,
    input  logic [cspe_pkg::FPS_W-1:0]    i_frames,
    input  logic [cspe_pkg::RECIP_W-1:0]  i_recip,
    output cspe_pkg::t_basis              o_basis
);

    localparam int P_W  = cspe_pkg::FRAME_W + cspe_pkg::RECIP_W;
    localparam int M_W  = cspe_pkg::Q16_W + cspe_pkg::FPS_W;
    localparam int SQ_W = 2 * cspe_pkg::Q16_W;
    localparam int QW   = cspe_pkg::Q16_W;
    localparam int HW   = cspe_pkg::H_W;
    localparam logic [SQ_W-1:0] HALF_Q = SQ_W'(1 << (cspe_pkg::Q_FRAC - 1));
    localparam logic signed [HW-1:0] Q_ONE = HW'(1 << cspe_pkg::Q_FRAC);

    logic [P_W-1:0]                 r_p1;
    logic [cspe_pkg::FRAME_W-1:0]   r_t1, r_t2, r_t3;
    logic [QW-1:0]                  r_q2, r_q3;
    logic [M_W-1:0]                 r_m3;
    logic [QW-1:0]                  r_s4, r_s5, r_s6;
    logic [SQ_W-1:0]                r_sq5;
    logic [SQ_W-1:0]                r_cu6;
    logic [QW-1:0]                  r_s2_6;
    cspe_pkg::t_basis               r_basis;

    logic [M_W-1:0]                 t_scaled;
    logic [M_W-1:0]                 rem;
    logic                           bump;
    logic [QW-1:0]                  s2_5;
    logic [QW-1:0]                  s3_6;
    logic signed [HW-1:0]           e_s, e_s2, e_s3, h2;

    // The product floor(t * floor(2^32/F) / 2^16) is low by at most one;
    // the remainder check restores the exact quotient.
    always_comb begin
        t_scaled = M_W'({r_t3, {cspe_pkg::Q_FRAC{1'b0}}});
        rem      = t_scaled - r_m3;
        bump     = (rem >= M_W'(i_frames));
        s2_5     = r_sq5[cspe_pkg::Q_FRAC +: QW];
        s3_6     = r_cu6[cspe_pkg::Q_FRAC +: QW];
        e_s      = $signed({{(HW-QW){1'b0}}, r_s6});
        e_s2     = $signed({{(HW-QW){1'b0}}, r_s2_6});
        e_s3     = $signed({{(HW-QW){1'b0}}, s3_6});
        h2       = e_s2 + (e_s2 <<< 1) - (e_s3 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= P_W'(i_t) * P_W'(i_recip);
        r_t1  <= i_t;

        r_q2  <= r_p1[cspe_pkg::Q_FRAC +: QW];
        r_t2  <= r_t1;

        r_m3  <= M_W'(r_q2) * M_W'(i_frames);
        r_q3  <= r_q2;
        r_t3  <= r_t2;

        r_s4  <= r_q3 + QW'(bump);

        r_sq5 <= SQ_W'(r_s4) * SQ_W'(r_s4) + HALF_Q;
        r_s5  <= r_s4;

        r_cu6  <= SQ_W'(s2_5) * SQ_W'(r_s5) + HALF_Q;
        r_s2_6 <= s2_5;
        r_s6   <= r_s5;

        r_basis.h2 <= h2;
        r_basis.h1 <= Q_ONE - h2;
        r_basis.h3 <= e_s3 - (e_s2 <<< 1) + e_s;
        r_basis.h4 <= e_s3 - e_s2;
    end

    assign o_basis = r_basis;

endmodule

### src/cspe_lane.sv
// One coordinate lane: tangents from the neighbors, weighted Hermite sum,
// round and saturate. Depends on cspe_pkg.

module cspe_lane #(
    parameter int CW = 16
) (
    input  logic                            i_clk,
    input  logic [cspe_pkg::TENSION_W-1:0]  i_tension,
    input  logic signed [CW-1:0]            i_prev,
    input  logic signed [CW-1:0]            i_start,
    input  logic signed [CW-1:0]            i_end,
    input  logic signed [CW-1:0]            i_next,
    input  cspe_pkg::t_basis                i_basis,
    output logic signed [CW-1:0]            o_value,
    output logic                            o_clip
);

    localparam int HW  = cspe_pkg::H_W;
    localparam int PW  = CW + 18;                 // diff times tension
    localparam int DW  = CW + 4;                  // rounded tangent
    localparam int AW  = HW + DW + 2;             // weighted sum
    localparam int DLY = cspe_pkg::BASIS_LAT - cspe_pkg::DERIV_LAT;
    localparam logic signed [PW-1:0] HALF_T = PW'(1 << (cspe_pkg::TENSION_FRAC - 1));
    localparam logic signed [AW-1:0] HALF_Q = AW'(1 << (cspe_pkg::Q_FRAC - 1));
    localparam logic signed [CW-1:0] V_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] V_MIN  = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW:0]      r_diff0, r_diff1;
    logic signed [CW-1:0]    r_p0_a, r_p1_a, r_p0_b, r_p1_b, r_p0_c, r_p1_c;
    logic signed [PW-1:0]    r_prod0, r_prod1;
    logic signed [DW-1:0]    r_d0, r_d1;

    logic signed [CW-1:0]    r_dl_p0 [DLY];
    logic signed [CW-1:0]    r_dl_p1 [DLY];
    logic signed [DW-1:0]    r_dl_d0 [DLY];
    logic signed [DW-1:0]    r_dl_d1 [DLY];

    logic signed [HW+CW-1:0] r_m1, r_m2;
    logic signed [HW+DW-1:0] r_m3, r_m4;
    logic signed [AW-1:0]    r_s12, r_s34;
    logic signed [CW-1:0]    r_value;
    logic                    r_clip;

    logic signed [PW-1:0]    rnd0, rnd1;
    logic signed [HW-1:0]    h1, h2, h3, h4;
    logic signed [AW-1:0]    acc, shifted;
    logic [AW-CW:0]          top_bits;
    logic                    ovf;

    always_comb begin
        rnd0     = (r_prod0 + HALF_T) >>> cspe_pkg::TENSION_FRAC;
        rnd1     = (r_prod1 + HALF_T) >>> cspe_pkg::TENSION_FRAC;
        h1       = i_basis.h1;
        h2       = i_basis.h2;
        h3       = i_basis.h3;
        h4       = i_basis.h4;
        acc      = r_s12 + r_s34 + HALF_Q;
        shifted  = acc >>> cspe_pkg::Q_FRAC;
        // Everything from the sign bit of the output range upward must agree.
        top_bits = shifted[AW-1:CW-1];
        ovf      = !((&top_bits) || (~|top_bits));
    end

    always_ff @(posedge i_clk) begin
        r_diff0 <= {i_end[CW-1], i_end} - {i_prev[CW-1], i_prev};
        r_diff1 <= {i_next[CW-1], i_next} - {i_start[CW-1], i_start};
        r_p0_a  <= i_start;
        r_p1_a  <= i_end;

        r_prod0 <= PW'(r_diff0) * PW'($signed({1'b0, i_tension}));
        r_prod1 <= PW'(r_diff1) * PW'($signed({1'b0, i_tension}));
        r_p0_b  <= r_p0_a;
        r_p1_b  <= r_p1_a;

        r_d0    <= rnd0[DW-1:0];
        r_d1    <= rnd1[DW-1:0];
        r_p0_c  <= r_p0_b;
        r_p1_c  <= r_p1_b;

        // Hold the lane operands until the shared basis weights arrive.
        for (int i = 0; i < DLY; i++) begin
            if (i == 0) begin
                r_dl_p0[i] <= r_p0_c;
                r_dl_p1[i] <= r_p1_c;
                r_dl_d0[i] <= r_d0;
                r_dl_d1[i] <= r_d1;
            end else begin
                r_dl_p0[i] <= r_dl_p0[i-1];
                r_dl_p1[i] <= r_dl_p1[i-1];
                r_dl_d0[i] <= r_dl_d0[i-1];
                r_dl_d1[i] <= r_dl_d1[i-1];
            end
        end

        r_m1 <= (HW+CW)'(h1) * (HW+CW)'(r_dl_p0[DLY-1]);
        r_m2 <= (HW+CW)'(h2) * (HW+CW)'(r_dl_p1[DLY-1]);
        r_m3 <= (HW+DW)'(h3) * (HW+DW)'(r_dl_d0[DLY-1]);
        r_m4 <= (HW+DW)'(h4) * (HW+DW)'(r_dl_d1[DLY-1]);

        r_s12 <= AW'(r_m1) + AW'(r_m2);
        r_s34 <= AW'(r_m3) + AW'(r_m4);

        r_clip  <= ovf;
        r_value <= ovf ? (shifted[AW-1] ? V_MIN : V_MAX) : shifted[CW-1:0];
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

### src/cspe_merge.sv
// Merge stage: joins the two lane results into one word and queues it for
// the output stream, with credit accounting for words in flight. Depends on cspe_pkg.

module cspe_merge #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_x,
    input  logic                 i_x_clip,
    input  logic signed [CW-1:0] i_y,
    input  logic                 i_y_clip,
    input  logic                 i_tready,
    output logic                 o_space,
    output logic                 o_tvalid,
    output logic [2*CW:0]        o_data
);

    localparam int DW = 2 * CW + 1;

    logic [DW-1:0]              r_mem [cspe_pkg::FIFO_DEPTH];
    logic [DW-1:0]              r_out;
    logic                       r_out_vld;
    logic [cspe_pkg::PTR_W-1:0] r_wptr, r_rptr;
    logic [cspe_pkg::CNT_W-1:0] r_fill, r_credit;
    logic [DW-1:0]              in_word;
    logic                       pop;
    logic                       out_free;
    logic                       load;
    logic                       bypass;
    logic                       mem_wr;

    assign in_word  = {i_x_clip | i_y_clip, i_y, i_x};
    assign pop      = r_out_vld && i_tready;
    assign out_free = !r_out_vld || pop;
    // The output register refills from the queue first; a word that finds the
    // queue empty while the output register is empty or being read goes straight to it.
    assign load     = out_free && (r_fill != '0);
    assign bypass   = out_free && (r_fill == '0) && i_vld;
    assign mem_wr   = i_vld && !bypass;
    assign o_tvalid = r_out_vld;
    assign o_data   = r_out;
    // Every accepted word holds a credit until it leaves, so the queue
    // always has room for what the lanes still produce.
    assign o_space  = (r_credit < cspe_pkg::CNT_W'(cspe_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wptr] <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_mem[r_rptr];
        end else if (bypass) begin
            r_out <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_fill    <= '0;
            r_credit  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_wptr <= r_wptr + cspe_pkg::PTR_W'(1);
            end
            if (load) begin
                r_rptr <= r_rptr + cspe_pkg::PTR_W'(1);
            end
            if (load || bypass) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
            r_fill   <= r_fill + cspe_pkg::CNT_W'(mem_wr) - cspe_pkg::CNT_W'(load);
            r_credit <= r_credit + cspe_pkg::CNT_W'(i_accept) - cspe_pkg::CNT_W'(pop);
        end
    end

endmodule

### src/cardinal_spline_point_eval_core.sv
// Cardinal spline point evaluator. Each input word carries four neighboring
// control points and a frame index and yields one output point; a new word is
// taken every clock while the reciprocal unit is idle and the queue has credit; the
// point passes the input registers, the basis and lane pipelines and the merge
// output register. Two lanes (x and y) run side by side on one shared Hermite
// basis pipeline; up to 16 words may be outstanding, queued at the output so
// stalls there reach the input only once that many are committed. After reset and
// after every frames_per_segment write the input is held off while a bit-serial
// unit forms the reciprocal of the frame count, one quotient bit per cycle.
// Depends on cspe_pkg, cspe_recip, cspe_basis, cspe_lane and cspe_merge.

module cardinal_spline_point_eval_core #(
    parameter  int COORD_BITS = 16,
    localparam int IN_W  = ((8 * COORD_BITS + cspe_pkg::FRAME_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // prev_x, prev_y, start_x, start_y, end_x, end_y, next_x, next_y, frame_index
    input  logic [IN_W-1:0]  s_axis_tdata,

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // curve_x, curve_y, saturated
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int CW = COORD_BITS;

    logic [cspe_pkg::TENSION_W-1:0] r_tension;
    logic [cspe_pkg::FPS_W-1:0]     r_fps;
    cspe_pkg::t_reg_idx             reg_idx;
    logic                           cfg_wr;
    logic                           fps_wr;
    logic [cspe_pkg::FPS_W-1:0]     f_eff;

    cspe_pkg::t_recip_stat          recip_stat;
    cspe_pkg::t_basis               basis;

    logic                           accept;
    logic                           space;
    logic [cspe_pkg::FRAME_W-1:0]   frame;
    logic [cspe_pkg::FRAME_W-1:0]   n_t;

    logic                           r_v0;
    logic [cspe_pkg::LANE_LAT-1:0]  r_vld;
    logic [cspe_pkg::FRAME_W-1:0]   r_t;
    logic signed [CW-1:0]           r_prev_x, r_prev_y, r_start_x, r_start_y;
    logic signed [CW-1:0]           r_end_x, r_end_y, r_next_x, r_next_y;

    logic signed [CW-1:0]           x_val, y_val;
    logic                           x_clip, y_clip;
    logic [2*CW:0]                  out_word;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = cspe_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign fps_wr  = cfg_wr && (reg_idx == cspe_pkg::REG_FPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= cspe_pkg::TENSION_RST;
            r_fps     <= cspe_pkg::FPS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                cspe_pkg::REG_TENSION: r_tension <= pwdata[cspe_pkg::TENSION_W-1:0];
                cspe_pkg::REG_FPS:     r_fps     <= pwdata[cspe_pkg::FPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cspe_pkg::REG_TENSION: prdata = 32'(r_tension);
            cspe_pkg::REG_FPS:     prdata = 32'(r_fps);
            default:               prdata = '0;
        endcase
    end

    assign f_eff = (r_fps < cspe_pkg::F_LO) ? cspe_pkg::F_LO :
                   ((r_fps > cspe_pkg::F_HI) ? cspe_pkg::F_HI : r_fps);

    cspe_recip u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (fps_wr),
        .i_frames (f_eff),
        .o_stat   (recip_stat)
    );

    // Input stage
    assign s_axis_tready = !recip_stat.busy && space;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign frame         = s_axis_tdata[8*CW +: cspe_pkg::FRAME_W];
    // Frames past the end of the segment give the end point.
    assign n_t = ({1'b0, frame} > f_eff) ? f_eff[cspe_pkg::FRAME_W-1:0] : frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_v0  <= accept;
            r_vld <= {r_vld[cspe_pkg::LANE_LAT-2:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x  <= s_axis_tdata[0*CW +: CW];
            r_prev_y  <= s_axis_tdata[1*CW +: CW];
            r_start_x <= s_axis_tdata[2*CW +: CW];
            r_start_y <= s_axis_tdata[3*CW +: CW];
            r_end_x   <= s_axis_tdata[4*CW +: CW];
            r_end_y   <= s_axis_tdata[5*CW +: CW];
            r_next_x  <= s_axis_tdata[6*CW +: CW];
            r_next_y  <= s_axis_tdata[7*CW +: CW];
            r_t       <= n_t;
        end
    end

    cspe_basis u_basis (
        .i_clk    (i_clk),
        .i_t      (r_t),
        .i_frames (f_eff),
        .i_recip  (recip_stat.recip),
        .o_basis  (basis)
    );

    cspe_lane #(.CW(CW)) u_lane_x (
        .i_clk     (i_clk),
        .i_tension (r_tension),
        .i_prev    (r_prev_x),
        .i_start   (r_start_x),
        .i_end     (r_end_x),
        .i_next    (r_next_x),
        .i_basis   (basis),
        .o_value   (x_val),
        .o_clip    (x_clip)
    );

    cspe_lane #(.CW(CW)) u_lane_y (
        .i_clk     (i_clk),
        .i_tension (r_tension),
        .i_prev    (r_prev_y),
        .i_start   (r_start_y),
        .i_end     (r_end_y),
        .i_next    (r_next_y),
        .i_basis   (basis),
        .o_value   (y_val),
        .o_clip    (y_clip)
    );

    cspe_merge #(.CW(CW)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_vld    (r_vld[cspe_pkg::LANE_LAT-1]),
        .i_x      (x_val),
        .i_x_clip (x_clip),
        .i_y      (y_val),
        .i_y_clip (y_clip),
        .i_tready (m_axis_tready),
        .o_space  (space),
        .o_tvalid (m_axis_tvalid),
        .o_data   (out_word)
    );

    assign m_axis_tdata = OUT_W'(out_word);

endmodule

### src/cspe_checker.sv
// Port-level checker for the cardinal spline point evaluator, bound to the top level.
// Depends on cspe_pkg and cardinal_spline_point_eval_core.

module cspe_checker #(
    parameter  int COORD_BITS = 16,
    localparam int OUT_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic [2:0]       paddr,
    input logic [31:0]      pwdata,
    input logic [31:0]      prdata,
    input logic             pready,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [cspe_pkg::CNT_W-1:0] r_outst;
    logic                       in_acc, out_acc, cfg_wr;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + cspe_pkg::CNT_W'(in_acc) - cspe_pkg::CNT_W'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_outst != '0))
        else $error("output word without a matching input word");

    a_credit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outst == cspe_pkg::CNT_W'(cspe_pkg::FIFO_DEPTH)) |-> !s_axis_tready)
        else $error("input taken with the output queue fully committed");

    a_fps_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2]) |=> !s_axis_tready)
        else $error("input taken while the reciprocal is being recomputed");

    a_tension_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && !paddr[2]) |=> (paddr[2] || (prdata[15:0] == $past(pwdata[15:0]))))
        else $error("tension register does not read back the written value");

endmodule

bind cardinal_spline_point_eval_core cspe_checker #(.COORD_BITS(COORD_BITS)) u_cspe_checker (.*);
